FILE: hdl/csv_field_tokenizer_core_assert.svh
// ----------------------------------------------------------------------------
// csv field tokenizer assertion macros
// shared concurrent assertion forms with an off switch
// ----------------------------------------------------------------------------
`ifndef CSV_FIELD_TOKENIZER_CORE_ASSERT_SVH
`define CSV_FIELD_TOKENIZER_CORE_ASSERT_SVH

`ifndef ASSERT_OFF
// same-cycle implication
`define CSVFT_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("%m: same-cycle check failed");
// next-cycle implication
`define CSVFT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("%m: next-cycle check failed");
`else
`define CSVFT_ASSERT_NOW(lbl, clk, rst_n, ante, cons)
`define CSVFT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

FILE: hdl/csvft_pkg.sv
// ----------------------------------------------------------------------------
// csvft_pkg
// codes and reset values shared by the csv field tokenizer
// ----------------------------------------------------------------------------
package csvft_pkg;

	localparam int CHAR_W = 8;
	localparam int IDX_W  = 8;
	localparam int APB_AW = 3;
	localparam int APB_DW = 32;

	localparam logic [CHAR_W-1:0] DELIM_RESET = 8'd44;
	localparam logic [CHAR_W-1:0] QUOTE_RESET = 8'd34;
	localparam logic [IDX_W-1:0]  FIELD_MAX   = 8'hFF;

	localparam logic REG_DELIM = 1'b0;
	localparam logic REG_QUOTE = 1'b1;

	localparam logic ACT_CHAR = 1'b0;
	localparam logic ACT_EOL  = 1'b1;

	localparam logic KIND_CHAR = 1'b0;
	localparam logic KIND_END  = 1'b1;

	typedef struct packed {
		logic              kind;
		logic [CHAR_W-1:0] char_out;
		logic [IDX_W-1:0]  field_index;
		logic              last_field;
	} result_t;

endpackage

FILE: hdl/csv_field_tokenizer_core.sv
// ----------------------------------------------------------------------------
// csv_field_tokenizer_core
// splits a csv line into field characters and field ends, with quoting
// ----------------------------------------------------------------------------
//  channel | signals                                      | direction
//  input   | in_valid, in_stall, action, char_in          | item in
//  output  | out_valid, out_stall, kind, char_out,        | result out
//          | field_index, last_field                      |
//  config  | psel, penable, pwrite, paddr, pwdata, prdata | apb slave
//
// one beat accepted per cycle while in_stall is low; its result is registered
// the line state flops are the only loop, updated once per beat
// a two-deep output stage (result register and skid) keeps input open
// while one result waits; in_stall rises only when the skid is full
// reset clears line state and restores the comma and double quote
// ----------------------------------------------------------------------------
`include "csv_field_tokenizer_core_assert.svh"

module csv_field_tokenizer_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          action,
	input  logic [csvft_pkg::CHAR_W-1:0]  char_in,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic                          kind,
	output logic [csvft_pkg::CHAR_W-1:0]  char_out,
	output logic [csvft_pkg::IDX_W-1:0]   field_index,
	output logic                          last_field,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [csvft_pkg::APB_AW-1:0]  paddr,
	input  logic [csvft_pkg::APB_DW-1:0]  pwdata,
	output logic [csvft_pkg::APB_DW-1:0]  prdata,
	output logic                          pready
);
	import csvft_pkg::*;

	logic [CHAR_W-1:0] delim_q;
	logic [CHAR_W-1:0] quote_q;

	logic             inside_q;
	logic             opened_q;
	logic             empty_q;
	logic             pending_q;
	logic [IDX_W-1:0] field_counter_q;

	logic             inside_nxt;
	logic             opened_nxt;
	logic             empty_nxt;
	logic             pending_nxt;
	logic [IDX_W-1:0] counter_nxt;

	logic    res_valid;
	result_t res;

	logic    out_valid_q;
	result_t out_q;
	logic    skid_valid_q;
	result_t skid_q;

	logic accept;
	logic cfg_wr;
	logic main_free;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign prdata = {{(APB_DW-CHAR_W){1'b0}}, (paddr[2] == REG_QUOTE) ? quote_q : delim_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delim_q <= DELIM_RESET;
			quote_q <= QUOTE_RESET;
		end else if (cfg_wr) begin
			if (paddr[2] == REG_QUOTE) begin
				quote_q <= pwdata[CHAR_W-1:0];
			end else begin
				delim_q <= pwdata[CHAR_W-1:0];
			end
		end
	end

	assign in_stall = skid_valid_q;
	assign accept   = in_valid && !in_stall;

	always_comb begin
		logic iq;
		logic done;
		iq          = inside_q;
		done        = 1'b0;
		inside_nxt  = inside_q;
		opened_nxt  = opened_q;
		empty_nxt   = empty_q;
		pending_nxt = pending_q;
		counter_nxt = field_counter_q;
		res_valid         = 1'b0;
		res.kind          = KIND_CHAR;
		res.char_out      = char_in;
		res.field_index   = field_counter_q;
		res.last_field    = 1'b0;
		if (action == ACT_EOL) begin
			res_valid    = 1'b1;
			res.kind     = KIND_END;
			res.char_out = '0;
			res.last_field = 1'b1;
			inside_nxt   = 1'b0;
			opened_nxt   = 1'b0;
			empty_nxt    = 1'b1;
			pending_nxt  = 1'b0;
			counter_nxt  = '0;
		end else begin
			if (pending_q) begin
				pending_nxt = 1'b0;
				if (char_in == quote_q) begin
					empty_nxt = 1'b0;
					res_valid = 1'b1;
					done      = 1'b1;
				end else begin
					iq = 1'b0;
				end
			end
			inside_nxt = iq;
			if (!done) begin
				if (char_in == quote_q) begin
					if (!opened_q && empty_q) begin
						inside_nxt = 1'b1;
						opened_nxt = 1'b1;
					end else if (iq) begin
						pending_nxt = 1'b1;
					end else begin
						empty_nxt = 1'b0;
						res_valid = 1'b1;
					end
				end else if (char_in == delim_q && !iq) begin
					res_valid    = 1'b1;
					res.kind     = KIND_END;
					res.char_out = '0;
					if (field_counter_q != FIELD_MAX) begin
						counter_nxt = field_counter_q + {{(IDX_W-1){1'b0}}, 1'b1};
					end
					empty_nxt  = 1'b1;
					opened_nxt = 1'b0;
				end else begin
					empty_nxt = 1'b0;
					res_valid = 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inside_q        <= 1'b0;
			opened_q        <= 1'b0;
			empty_q         <= 1'b1;
			pending_q       <= 1'b0;
			field_counter_q <= '0;
		end else if (accept) begin
			inside_q        <= inside_nxt;
			opened_q        <= opened_nxt;
			empty_q         <= empty_nxt;
			pending_q       <= pending_nxt;
			field_counter_q <= counter_nxt;
		end
	end

	assign main_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (main_free) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= accept && res_valid;
			end
		end else if (accept && res_valid) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (main_free) begin
			out_q <= skid_valid_q ? skid_q : res;
		end
		if (!main_free && accept && res_valid) begin
			skid_q <= res;
		end
	end

	assign out_valid   = out_valid_q;
	assign kind        = out_q.kind;
	assign char_out    = out_q.char_out;
	assign field_index = out_q.field_index;
	assign last_field  = out_q.last_field;

	`CSVFT_ASSERT_NOW(a_skid_behind_main, clk, arst_n, skid_valid_q, out_valid_q)
	`CSVFT_ASSERT_NOW(a_pending_in_quotes, clk, arst_n, pending_q, inside_q)
	`CSVFT_ASSERT_NOW(a_inside_opened, clk, arst_n, inside_q, opened_q)
	`CSVFT_ASSERT_NEXT(a_eol_clears, clk, arst_n, accept && action == ACT_EOL,
		field_counter_q == '0 && !inside_q && empty_q)
	`CSVFT_ASSERT_NEXT(a_skid_drains, clk, arst_n, skid_valid_q && !out_stall, !skid_valid_q)

endmodule
